// ----- rtl/core/mpf_pkg.sv -----
package mpf_pkg;

  // Field widths.
  localparam int unsigned IdW    = 8;
  localparam int unsigned CountW = 8;
  localparam int unsigned PayW   = 24;
  localparam int unsigned WordW  = 32;
  localparam int unsigned SentW  = 22;
  localparam int unsigned IdxW   = 2;

  // Most words one item can produce: header, data and end.
  localparam int unsigned MaxWords = 3;

  // Checksum constants.
  localparam logic [PayW-1:0] CkSeed = 24'hA50000;
  localparam logic [12:0]     CkStep = 13'h1021;

  // Word tags.
  localparam logic [WordW-1:0] TagHeader = 32'hC000_0000;
  localparam logic [WordW-1:0] TagData   = 32'hC100_0000;
  localparam logic [WordW-1:0] TagEnd    = 32'hC200_0000;

  typedef logic [WordW-1:0] word_t;
  typedef logic [1:0]       word_cnt_t;

endpackage

// ----- rtl/core/mailbox_page_framer.sv -----
// Mailbox page framer: turns payload items into header, data and end words.
// The first word of an item appears the cycle after the item is accepted.
// Throughput: one item per cycle inside a page while out_stall is low; an item that
// opens or closes a page makes two or three words and stalls input until they leave.
// Reset: synchronous, active low; clears page position, checksum and word count.
module mailbox_page_framer
  import mpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [IdW-1:0]    in_page_id,
  input  logic [CountW-1:0] in_payload_count,
  input  logic [PayW-1:0]   in_payload,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WordW-1:0]  out_mailbox_word,
  output logic              out_last_of_run,
  output logic              out_page_done
);

  // Page state.
  logic [CountW-1:0] pos_r, pos_nxt;
  logic [CountW-1:0] cnt_r, cnt_nxt;
  logic [PayW-1:0]   ck_r, ck_nxt;

  // Word buffer: entry 0 is presented, later entries shift down as words leave.
  word_t     word_r [MaxWords];
  word_t     word_nxt [MaxWords];
  word_cnt_t rem_r, rem_nxt;
  logic      end_r, end_nxt;

  logic take;
  logic accept;

  // Per-item datapath.
  logic              open_page;
  logic [CountW-1:0] cnt_eff;
  logic [PayW-1:0]   ck_base;
  logic [PayW-1:0]   ck_data;
  logic [CountW:0]   pos_inc;
  logic [20:0]       step_term;
  logic [CountW-1:0] pos_after;
  logic              close_page;
  word_t             hdr_word;
  word_t             data_word;
  word_t             end_base_word;
  word_t             end_data_word;

  // Handshake: a new item may enter as the last buffered word leaves.
  assign out_valid = (rem_r != 2'd0);
  assign take      = out_valid && !out_stall;
  assign in_stall  = out_valid && !(take && (rem_r == 2'd1));
  assign accept    = in_valid && !in_stall;

  assign out_mailbox_word = word_r[0];
  assign out_last_of_run  = (rem_r == 2'd1);
  assign out_page_done    = (rem_r == 2'd1) && end_r;

  // Checksum and word formation for the incoming item.
  always_comb begin
    open_page  = (pos_r == '0);
    cnt_eff    = open_page ? in_payload_count : cnt_r;
    ck_base    = open_page ? (CkSeed ^ {8'd0, in_page_id, 8'd0} ^ {16'd0, in_payload_count})
                           : ck_r;
    pos_inc    = {1'b0, pos_r} + 9'd1;
    step_term  = 21'(pos_inc * CkStep);
    ck_data    = ck_base ^ in_payload ^ {3'd0, step_term};
    pos_after  = pos_inc[CountW-1:0];
    close_page = (pos_after == cnt_eff);
    hdr_word   = TagHeader | {8'd0, in_page_id, 8'd0, in_payload_count};
    data_word  = TagData | {8'd0, pos_r[IdxW-1:0], in_payload[SentW-1:0]};
    end_base_word = TagEnd | {8'd0, ck_base};
    end_data_word = TagEnd | {8'd0, ck_data};
  end

  // Next state of the page and the word buffer.
  always_comb begin
    pos_nxt = pos_r;
    cnt_nxt = cnt_r;
    ck_nxt  = ck_r;
    rem_nxt = rem_r;
    end_nxt = end_r;
    for (int k = 0; k < MaxWords; k++) begin
      word_nxt[k] = word_r[k];
    end
    if (accept) begin
      if (open_page) begin
        cnt_nxt = in_payload_count;
      end
      if (open_page && (in_payload_count == '0)) begin
        // Empty page: header and end only, payload ignored.
        ck_nxt      = ck_base;
        pos_nxt     = '0;
        word_nxt[0] = hdr_word;
        word_nxt[1] = end_base_word;
        rem_nxt     = 2'd2;
        end_nxt     = 1'b1;
      end else begin
        ck_nxt  = ck_data;
        pos_nxt = close_page ? '0 : pos_after;
        end_nxt = close_page;
        if (open_page) begin
          word_nxt[0] = hdr_word;
          word_nxt[1] = data_word;
          word_nxt[2] = end_data_word;
          rem_nxt     = close_page ? 2'd3 : 2'd2;
        end else begin
          word_nxt[0] = data_word;
          word_nxt[1] = end_data_word;
          rem_nxt     = close_page ? 2'd2 : 2'd1;
        end
      end
    end else if (take) begin
      // Shift the next buffered word into the output slot.
      word_nxt[0] = word_r[1];
      word_nxt[1] = word_r[2];
      rem_nxt     = rem_r - 2'd1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cnt_r <= '0;
      ck_r  <= '0;
      rem_r <= '0;
      end_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
      ck_r  <= ck_nxt;
      rem_r <= rem_nxt;
      end_r <= end_nxt;
    end
  end

  // Word buffer payload needs no reset.
  always_ff @(posedge clk) begin
    for (int k = 0; k < MaxWords; k++) begin
      word_r[k] <= word_nxt[k];
    end
  end

endmodule

// ----- bench/tb_mailbox_page_framer.sv -----
module tb_mailbox_page_framer;
  import mpf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One mailbox word together with its side flags.
  typedef struct packed {
    word_t word;
    logic  last;
    logic  done;
  } mbox_word_t;

  // Tracks the framer state and holds the mailbox words still owed by the block.
  class page_frame_scoreboard;
    mbox_word_t         pending_words[$];
    logic [CountW-1:0]  position;
    logic [PayW-1:0]    checksum;
    logic [IdW-1:0]     held_id;
    logic [CountW-1:0]  held_count;
    int                 mismatches;

    function void clear_state();
      position   = '0;
      checksum   = '0;
      held_id    = '0;
      held_count = '0;
      mismatches = 0;
      pending_words.delete();
    endfunction

    function int words_pending();
      return pending_words.size();
    endfunction

    function void push_word(word_t word, logic last, logic done);
      mbox_word_t w;
      w.word = word;
      w.last = last;
      w.done = done;
      pending_words.push_back(w);
    endfunction

    // Works out the words that one accepted item causes.
    function void frame_item(logic [IdW-1:0] id, logic [CountW-1:0] cnt,
                             logic [PayW-1:0] pay);
      logic [CountW-1:0] idx;
      logic [PayW-1:0]   step;
      word_t             data;
      // A new page latches id and count, seeds the checksum and sends the header.
      if (position == '0) begin
        held_id    = id;
        held_count = cnt;
        checksum   = CkSeed ^ {8'h00, id, 8'h00} ^ {16'h0000, cnt};
        if (cnt == '0) begin
          push_word(TagHeader | {8'h00, id, 8'h00, cnt}, 1'b0, 1'b0);
          push_word(TagEnd | {8'h00, checksum}, 1'b1, 1'b1);
          return;
        end
        push_word(TagHeader | {8'h00, id, 8'h00, cnt}, 1'b0, 1'b0);
      end
      // Fold the payload and its position into the checksum and send the data word.
      idx      = position;
      step     = PayW'((32'(idx) + 32'd1) * 32'(CkStep));
      checksum = checksum ^ pay ^ step;
      data     = TagData | {8'h00, idx[IdxW-1:0], pay[SentW-1:0]};
      position = idx + 8'd1;
      if (position == held_count) begin
        push_word(data, 1'b0, 1'b0);
        push_word(TagEnd | {8'h00, checksum}, 1'b1, 1'b1);
        position = '0;
      end else begin
        push_word(data, 1'b1, 1'b0);
      end
    endfunction

    // Compares one accepted word with the oldest expectation.
    function void check_word(word_t word, logic last, logic done);
      mbox_word_t want;
      if (pending_words.size() == 0) begin
        $error("unexpected mailbox word %h", word);
        mismatches++;
        return;
      end
      want = pending_words.pop_front();
      if (word !== want.word) begin
        $error("mailbox_word: expected %h, actual %h", want.word, word);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %b, actual %b", want.last, last);
        mismatches++;
      end
      if (done !== want.done) begin
        $error("page_done: expected %b, actual %b", want.done, done);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [IdW-1:0]    in_page_id = '0;
  logic [CountW-1:0] in_payload_count = '0;
  logic [PayW-1:0]   in_payload = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  word_t             out_mailbox_word;
  logic              out_last_of_run;
  logic              out_page_done;

  page_frame_scoreboard sb = new;

  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  int holds_asked = 0;

  mailbox_page_framer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_page_id       (in_page_id),
    .in_payload_count (in_payload_count),
    .in_payload       (in_payload),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mailbox_word (out_mailbox_word),
    .out_last_of_run  (out_last_of_run),
    .out_page_done    (out_page_done)
  );

  // Free-running clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit in case the block hangs.
  initial begin
    #2_000_000;
    $display("FAIL mailbox_page_framer");
    $finish;
  end

  // Receiver: random stalls, plus long hold-offs when the stimulus asks for one.
  initial begin
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= rx_idle_en && ($urandom_range(0, 99) < 22);
      end
    end
  end

  // Check every word the block hands over.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_word(out_mailbox_word, out_last_of_run, out_page_done);
    end
  end

  // Offers one item, with an optional random gap first, and waits for acceptance.
  task automatic send_item(input logic [IdW-1:0] id, input logic [CountW-1:0] cnt,
                           input logic [PayW-1:0] pay);
    while (tx_idle_en && ($urandom_range(0, 99) < 22)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_page_id       <= id;
    in_payload_count <= cnt;
    in_payload       <= pay;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.frame_item(id, cnt, pay);
  endtask

  // Sends a whole page; items after the first carry random, ignored id and count.
  task automatic send_page(input logic [CountW-1:0] cnt, inout int sent);
    int n;
    n = (cnt == '0) ? 1 : int'(cnt);
    send_item(IdW'($urandom()), cnt, PayW'($urandom()));
    for (int k = 1; k < n; k++) begin
      send_item(IdW'($urandom()), CountW'($urandom()), PayW'($urandom()));
    end
    sent += n;
  endtask

  // Stops offering and waits until every owed word has come out.
  task automatic wait_for_words();
    in_valid <= 1'b0;
    while (sb.words_pending() != 0) @(posedge clk);
  endtask

  // Stimulus: directed pages, random pages, back-pressure and a stretch without idling.
  initial begin
    int sent;
    int r;
    logic [CountW-1:0] cnt;
    sent = 0;
    sb.clear_state();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Zero-count pages at the id and payload extremes; the payload is ignored.
    send_item(8'h00, 8'h00, 24'hFFFFFF);
    send_item(8'hFF, 8'h00, 24'h000000);
    // Single-payload pages give header, data and end from one item.
    send_item(8'hFF, 8'h01, 24'hFFFFFF);
    send_item(8'h00, 8'h01, 24'h000000);
    // A six-payload page wraps the index; id and count inside the page are ignored.
    send_item(8'hA5, 8'h06, 24'h123456);
    send_item(8'hFF, 8'hFF, 24'h3FFFFF);
    send_item(8'h00, 8'h00, 24'hC00000);
    send_item(8'hFF, 8'h00, 24'h555555);
    send_item(8'h00, 8'hFF, 24'hAAAAAA);
    send_item(8'h5A, 8'h01, 24'h000001);
    send_item(8'h5A, 8'h02, 24'hFFFFFF);
    send_item(8'h01, 8'h01, 24'h800000);
    sent = 12;
    wait_for_words();

    // Random pages, mostly short, with both sides idling.
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    while (sent < 45) begin
      r = $urandom_range(0, 99);
      cnt = (r < 10) ? 8'd0 : (r < 80) ? CountW'($urandom_range(1, 6))
                                       : CountW'($urandom_range(7, 24));
      send_page(cnt, sent);
    end

    // Receiver holds off while the sender keeps offering, so the block backs up.
    tx_idle_en = 1'b0;
    holds_asked++;
    send_page(8'd20, sent);
    // Sender pauses until every owed word has come out.
    wait_for_words();

    // A long stretch with no idling at all, over two back-to-back pages.
    rx_idle_en = 1'b0;
    send_page(8'd24, sent);
    send_page(8'd3, sent);

    // More random pages with idling back on.
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    while (sent < 120) begin
      r = $urandom_range(0, 99);
      cnt = (r < 10) ? 8'd0 : (r < 80) ? CountW'($urandom_range(1, 6))
                                       : CountW'($urandom_range(7, 24));
      send_page(cnt, sent);
    end

    // Drain, then keep watching for any stray words before the verdict.
    wait_for_words();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS mailbox_page_framer");
    end else begin
      $display("FAIL mailbox_page_framer");
    end
    $finish;
  end

endmodule
